// File: hw/rtl/fpbs_pkg.sv
// ----------------------------------------------------------------------------
// fpbs_pkg: shared types and constants for the fit policy block selector
// Policy and status codes, item structs, candidate struct and merge function.
// ----------------------------------------------------------------------------
`default_nettype none

package fpbs_pkg;

   localparam int NUM_BLOCKS    = 8;   // slots that take part in selection (2..8)
   localparam int SIZE_WIDTH    = 16;  // compared size width (4..32)
   localparam int SLOT_REGS     = 8;   // size registers present
   localparam int REG_WIDTH     = 16;
   localparam int IDX_WIDTH     = 3;
   localparam int CSR_IDX_WIDTH = 4;
   localparam int CMP_WIDTH     = (SIZE_WIDTH < REG_WIDTH) ? SIZE_WIDTH : REG_WIDTH;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;
   localparam logic [1:0] POL_BAD   = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_BADPOL = 2'd2;

   typedef struct packed {
      logic [1:0]           operation;
      logic [REG_WIDTH-1:0] request_size;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [IDX_WIDTH-1:0] block_index;
      logic [REG_WIDTH-1:0] chosen_size;
   } rsp_type;

   typedef logic [SLOT_REGS-1:0][REG_WIDTH-1:0] size_array_type;

   typedef struct packed {
      logic                 fit;
      logic [IDX_WIDTH-1:0] idx;
      logic [CMP_WIDTH-1:0] size;
   } cand_type;

   typedef struct packed {
      logic [1:0]                      policy;
      cand_type [SLOT_REGS-1:0]        cands;
   } grp8_type;

   typedef struct packed {
      logic [1:0]                      policy;
      cand_type [SLOT_REGS/2-1:0]      cands;
   } grp4_type;

   typedef struct packed {
      logic [1:0]                      policy;
      cand_type [SLOT_REGS/4-1:0]      cands;
   } grp2_type;

   // lo always has the lower slot indexes, so ties keep lo
   function automatic cand_type merge_cand(input logic [1:0] policy,
                                           input cand_type lo,
                                           input cand_type hi);
      logic take_lo;
      begin
         case (policy)
            POL_BEST:  take_lo = lo.fit && (!hi.fit || lo.size <= hi.size);
            POL_WORST: take_lo = lo.fit && (!hi.fit || lo.size >= hi.size);
            default:   take_lo = lo.fit;
         endcase
         merge_cand = take_lo ? lo : hi;
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fpbs_csr.sv
// ----------------------------------------------------------------------------
// fpbs_csr: block size register file
// Eight write-only size registers; writes past the last index are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbs_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [fpbs_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [fpbs_pkg::REG_WIDTH-1:0]     csr_data,
   output fpbs_pkg::size_array_type                sizes
);

   fpbs_pkg::size_array_type sizes_ff;
   fpbs_pkg::size_array_type sizes_in;

   always_comb begin
      sizes_in = sizes_ff;
      for (int k = 0; k < fpbs_pkg::SLOT_REGS; k++) begin
         if (csr_we && csr_index == fpbs_pkg::CSR_IDX_WIDTH'(k)) begin
            sizes_in[k] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sizes_ff <= '0;
      end else begin
         sizes_ff <= sizes_in;
      end
   end

   assign sizes = sizes_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fpbs_match.sv
// ----------------------------------------------------------------------------
// fpbs_match: compare stage
// Tests every slot against the request and registers one candidate per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbs_match (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire fpbs_pkg::req_type        in_data,
   input  wire fpbs_pkg::size_array_type sizes,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output fpbs_pkg::grp8_type            out_data
);

   logic               valid_ff;
   logic               valid_in;
   fpbs_pkg::grp8_type data_ff;
   fpbs_pkg::grp8_type data_in;
   logic [fpbs_pkg::CMP_WIDTH-1:0] req_size;

   assign in_ready = !valid_ff || out_ready;
   assign req_size = in_data.request_size[fpbs_pkg::CMP_WIDTH-1:0];

   always_comb begin
      data_in.policy = in_data.operation;
      for (int k = 0; k < fpbs_pkg::SLOT_REGS; k++) begin
         data_in.cands[k].size = sizes[k][fpbs_pkg::CMP_WIDTH-1:0];
         data_in.cands[k].idx  = fpbs_pkg::IDX_WIDTH'(k);
         // unused slot (size zero) never fits, not even a zero request
         data_in.cands[k].fit  = (k < fpbs_pkg::NUM_BLOCKS)
                                 && (data_in.cands[k].size != '0)
                                 && (data_in.cands[k].size >= req_size);
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fpbs_tree.sv
// ----------------------------------------------------------------------------
// fpbs_tree: two registered merge levels
// Reduces eight candidates to four, then four to two, per the item's policy.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbs_tree (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire fpbs_pkg::grp8_type       in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output fpbs_pkg::grp2_type            out_data
);

   logic               l1_valid_ff;
   logic               l1_valid_in;
   fpbs_pkg::grp4_type l1_data_ff;
   fpbs_pkg::grp4_type l1_data_in;
   logic               l1_ready;

   logic               l2_valid_ff;
   logic               l2_valid_in;
   fpbs_pkg::grp2_type l2_data_ff;
   fpbs_pkg::grp2_type l2_data_in;
   logic               l2_ready;

   assign l2_ready = !l2_valid_ff || out_ready;
   assign l1_ready = !l1_valid_ff || l2_ready;
   assign in_ready = l1_ready;

   always_comb begin
      l1_data_in.policy = in_data.policy;
      for (int k = 0; k < fpbs_pkg::SLOT_REGS / 2; k++) begin
         l1_data_in.cands[k] = fpbs_pkg::merge_cand(in_data.policy,
                                                    in_data.cands[2*k],
                                                    in_data.cands[2*k+1]);
      end
      l2_data_in.policy = l1_data_ff.policy;
      for (int k = 0; k < fpbs_pkg::SLOT_REGS / 4; k++) begin
         l2_data_in.cands[k] = fpbs_pkg::merge_cand(l1_data_ff.policy,
                                                    l1_data_ff.cands[2*k],
                                                    l1_data_ff.cands[2*k+1]);
      end
      l1_valid_in = l1_ready ? in_valid : l1_valid_ff;
      l2_valid_in = l2_ready ? l1_valid_ff : l2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff <= 1'b0;
         l2_valid_ff <= 1'b0;
      end else begin
         l1_valid_ff <= l1_valid_in;
         l2_valid_ff <= l2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && l1_ready) begin
         l1_data_ff <= l1_data_in;
      end
      if (l1_valid_ff && l2_ready) begin
         l2_data_ff <= l2_data_in;
      end
   end

   assign out_valid = l2_valid_ff;
   assign out_data  = l2_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fpbs_out.sv
// ----------------------------------------------------------------------------
// fpbs_out: final merge and result register
// Picks the last winner, builds status, index and size, holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbs_out (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire fpbs_pkg::grp2_type       in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output fpbs_pkg::rsp_type             out_data
);

   logic               valid_ff;
   logic               valid_in;
   fpbs_pkg::rsp_type  data_ff;
   fpbs_pkg::rsp_type  data_in;
   fpbs_pkg::cand_type win;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      win = fpbs_pkg::merge_cand(in_data.policy, in_data.cands[0], in_data.cands[1]);
      data_in = '0;
      if (in_data.policy == fpbs_pkg::POL_BAD) begin
         data_in.status = fpbs_pkg::ST_BADPOL;
      end else if (win.fit) begin
         data_in.status      = fpbs_pkg::ST_OK;
         data_in.block_index = win.idx;
         data_in.chosen_size = fpbs_pkg::REG_WIDTH'(win.size);
      end else begin
         data_in.status = fpbs_pkg::ST_NOFIT;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fit_policy_block_selector.sv
// ----------------------------------------------------------------------------
// fit_policy_block_selector: first / best / worst fit block slot selector
// Picks one of eight configured block sizes for each request item.
// ----------------------------------------------------------------------------
// Each request item carries a policy (first, best or worst fit, or the
// invalid code) and a size; the result item gives a status, the chosen slot
// and its size. Slot sizes live in eight registers written through the csr_
// port; a size of zero marks the slot unused, and writes to index 8 and up
// are dropped. Write them only while no item is in flight. The block takes
// one item per cycle while no stall on rsp_ready backs up the pipe, and
// each result passes in order through the registers of the four-stage
// pipeline: per-slot compare, then three levels of a pairwise merge tree
// (8 to 4, 4 to 2, 2 to 1 plus result formatting into the output register).
// Every stage has its own valid bit and is refilled whenever it or the
// stage after it empties, so bubbles collapse and a full pipe holds its
// items under back-pressure. Ties on size go to the lowest slot index.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_selector (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request items
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire fpbs_pkg::req_type                  req_data,
   // result items
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output fpbs_pkg::rsp_type                       rsp_data,
   // size register writes
   input  wire logic                               csr_we,
   input  wire logic [fpbs_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [fpbs_pkg::REG_WIDTH-1:0]     csr_data
);

   fpbs_pkg::size_array_type sizes;

   // compare stage -> tree
   logic               s1_valid;
   logic               s1_ready;
   fpbs_pkg::grp8_type s1_data;

   // tree -> final stage
   logic               s3_valid;
   logic               s3_ready;
   fpbs_pkg::grp2_type s3_data;

   fpbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .sizes     (sizes)
   );

   // stage 1: fit flags for all slots at once
   fpbs_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .sizes     (sizes),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   // stages 2 and 3: merge tree down to two candidates
   fpbs_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   // stage 4: last merge, status encode, output register
   fpbs_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hw/rtl/fpbs_chk.sv
// ----------------------------------------------------------------------------
// fpbs_chk: port-level checks for the fit policy block selector
// Result encoding rules and output hold under stall; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbs_chk (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire fpbs_pkg::rsp_type rsp_data
);

   // reserved status code never shows
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == fpbs_pkg::ST_OK
                     || rsp_data.status == fpbs_pkg::ST_NOFIT
                     || rsp_data.status == fpbs_pkg::ST_BADPOL))
      else $error("fpbs: reserved status code on result item");

   // no allocation -> index and size are zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != fpbs_pkg::ST_OK)
      |-> (rsp_data.block_index == '0 && rsp_data.chosen_size == '0))
      else $error("fpbs: nonzero index or size without allocation");

   // an unused slot is never chosen
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == fpbs_pkg::ST_OK) |-> rsp_data.chosen_size != '0)
      else $error("fpbs: allocated a zero-size slot");

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("fpbs: result item changed while stalled");

endmodule

bind fit_policy_block_selector fpbs_chk u_fpbs_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
